FILE: src/tid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tid_pkg;

	// Instruction classes
	localparam logic [6:0] MN_LSL_I         = 7'd0;
	localparam logic [6:0] MN_ADD_R         = 7'd3;
	localparam logic [6:0] MN_MOV_I8        = 7'd7;
	localparam logic [6:0] MN_ALU_BASE      = 7'd11;
	localparam logic [6:0] MN_ADD_HI        = 7'd27;
	localparam logic [6:0] MN_NOP           = 7'd30;
	localparam logic [6:0] MN_BLX_R         = 7'd31;
	localparam logic [6:0] MN_BX            = 7'd32;
	localparam logic [6:0] MN_LDST_REG_BASE = 7'd33;
	localparam logic [6:0] MN_LDST_HS_BASE  = 7'd37;
	localparam logic [6:0] MN_LDR_PC        = 7'd41;
	localparam logic [6:0] MN_LDST_I5_BASE  = 7'd42;
	localparam logic [6:0] MN_STRH_I        = 7'd46;
	localparam logic [6:0] MN_LDRH_I        = 7'd47;
	localparam logic [6:0] MN_STR_SP        = 7'd48;
	localparam logic [6:0] MN_LDR_SP        = 7'd49;
	localparam logic [6:0] MN_ADD_PC        = 7'd50;
	localparam logic [6:0] MN_ADD_SPR       = 7'd51;
	localparam logic [6:0] MN_ADD_SP_I      = 7'd52;
	localparam logic [6:0] MN_PUSH          = 7'd53;
	localparam logic [6:0] MN_POP           = 7'd54;
	localparam logic [6:0] MN_BKPT          = 7'd55;
	localparam logic [6:0] MN_UNDEF         = 7'd56;
	localparam logic [6:0] MN_STMIA         = 7'd57;
	localparam logic [6:0] MN_LDMIA         = 7'd58;
	localparam logic [6:0] MN_BCOND         = 7'd59;
	localparam logic [6:0] MN_SWI           = 7'd60;
	localparam logic [6:0] MN_B             = 7'd61;
	localparam logic [6:0] MN_BLX_H         = 7'd62;
	localparam logic [6:0] MN_BL_P1         = 7'd63;
	localparam logic [6:0] MN_BL_H          = 7'd64;

	// Fixed register numbers
	localparam logic [3:0] REG_SP = 4'd13;
	localparam logic [3:0] REG_PC = 4'd15;

	// Condition codes outside the branch range
	localparam logic [3:0] COND_UNDEF = 4'd14;

	localparam logic [7:0]  NOP_LOW_BYTE   = 8'hC0;
	localparam logic [31:0] ROM_BASE_RESET = 32'h0800_0000;
	localparam logic [31:0] PC_AHEAD       = 32'd4;
	localparam logic [31:0] LIT_ALIGN_MASK = ~32'd2;

	typedef struct packed {
		logic [15:0] opcode;
		logic [31:0] instr_address;
	} in_word_t;

	typedef struct packed {
		logic [6:0]         mnemonic;
		logic [3:0]         condition;
		logic [3:0]         dest_reg;
		logic [3:0]         src_reg;
		logic [2:0]         offset_reg;
		logic signed [23:0] immediate;
		logic [8:0]         reg_list;
		logic               falls_through;
		logic               code_target_valid;
		logic [31:0]        code_target;
		logic               data_target_valid;
		logic [31:0]        data_target;
	} out_word_t;

	// Address work requested by the decoder
	typedef struct packed {
		logic        code_en;
		logic [10:0] soff;
		logic        data_en;
		logic [7:0]  imm8;
	} tgt_req_t;

endpackage

`default_nettype wire

FILE: src/thumb_instruction_decoder_core.sv
// Thumb halfword decoder.
// Input channel: in_valid / in_stall / in_data carry one word per item, the
// opcode and its address. Output channel: out_valid / out_stall / out_data
// carry the decoded word. The receiver of each channel drives its stall.
// Configuration: cfg_valid / cfg_ready / cfg_data write rom_base; cfg_ready
// is always high, and writes belong in idle periods only.
// Datapath: one input register, the decode and address adders, one result
// register. out_valid is driven by the result register.
// Throughput is one word per cycle while the output does not stall; the pipeline
// advances as one unit, so the figure is set by the single decode stage.
// A stall from the output holds both registers, and in_stall follows it
// combinationally when the result register is full.
// Reset empties both stages and loads rom_base with 0x08000000.
`timescale 1ns / 1ps
`default_nettype none

module thumb_instruction_decoder_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tid_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tid_pkg::out_word_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [31:0]        cfg_data
);

	logic                valid_s1;
	tid_pkg::in_word_t   word_s1;
	logic                valid_s2;
	tid_pkg::out_word_t  word_s2;
	logic [31:0]         rom_base_q;
	logic                advance;
	tid_pkg::out_word_t  dec_fields;
	tid_pkg::tgt_req_t   dec_req;
	tid_pkg::out_word_t  dec_result;

	// Whole pipeline moves unless a finished word is held downstream
	assign advance   = ~(valid_s2 & out_stall);
	assign in_stall  = ~advance;
	assign cfg_ready = 1'b1;
	assign out_valid = valid_s2;
	assign out_data  = word_s2;

	// Stage valids and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			rom_base_q <= tid_pkg::ROM_BASE_RESET;
		end else begin
			if (advance) begin
				valid_s1 <= in_valid;
				valid_s2 <= valid_s1;
			end
			if (cfg_valid && cfg_ready) rom_base_q <= cfg_data;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			word_s1 <= in_data;
			word_s2 <= dec_result;
		end
	end

	tid_decode u_decode (
		.opcode (word_s1.opcode),
		.fields (dec_fields),
		.req    (dec_req)
	);

	tid_target u_target (
		.fields        (dec_fields),
		.req           (dec_req),
		.instr_address (word_s1.instr_address),
		.rom_base      (rom_base_q),
		.result        (dec_result)
	);

`ifndef SYNTHESIS
	// A decoded word in stage 1 reaches the output when the pipe moves
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid)
		else $error("stage 1 word lost");

	// Only one kind of target per word
	a_one_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.code_target_valid && out_data.data_target_valid))
		else $error("code and data target both reported");

	// Control leaves the fall-through path only for BX, POP and B
	a_no_fall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.falls_through |->
			(out_data.mnemonic == tid_pkg::MN_BX || out_data.mnemonic == tid_pkg::MN_POP ||
			 out_data.mnemonic == tid_pkg::MN_B))
		else $error("unexpected non fall-through class");
`endif

endmodule

`default_nettype wire

FILE: src/tid_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module tid_decode (
	input  wire logic [15:0]       opcode,
	output tid_pkg::out_word_t     fields,
	output tid_pkg::tgt_req_t      req
);

	logic [15:0] op;
	logic [2:0]  r0, r3, r6, r8;
	logic [7:0]  imm8;
	logic [4:0]  imm5;
	logic [8:0]  sp_mag;

	assign op     = opcode;
	assign r0     = op[2:0];
	assign r3     = op[5:3];
	assign r6     = op[8:6];
	assign r8     = op[10:8];
	assign imm8   = op[7:0];
	assign imm5   = op[10:6];
	assign sp_mag = {op[6:0], 2'b00};

	// Class and field extraction, by the top three opcode bits
	always_comb begin
		fields                   = '0;
		fields.falls_through     = 1'b1;
		req                      = '0;
		req.imm8                 = imm8;
		unique case (op[15:13])
			3'd0: begin
				fields.dest_reg = {1'b0, r0};
				fields.src_reg  = {1'b0, r3};
				if (op[12:11] != 2'd3) begin
					fields.mnemonic  = tid_pkg::MN_LSL_I + {5'd0, op[12:11]};
					fields.immediate = {19'd0, imm5};
				end else begin
					fields.mnemonic = tid_pkg::MN_ADD_R + {5'd0, op[10:9]};
					if (!op[10]) fields.offset_reg = r6;
					else         fields.immediate  = {21'd0, r6};
				end
			end
			3'd1: begin
				fields.mnemonic  = tid_pkg::MN_MOV_I8 + {5'd0, op[12:11]};
				fields.dest_reg  = {1'b0, r8};
				fields.immediate = {16'd0, imm8};
			end
			3'd2: begin
				unique case (op[12:10]) inside
					3'd0: begin
						fields.mnemonic = tid_pkg::MN_ALU_BASE + {3'd0, op[9:6]};
						fields.dest_reg = {1'b0, r0};
						fields.src_reg  = {1'b0, r3};
					end
					3'd1: begin
						// High register ops and BX/BLX
						if (op[9:8] == 2'd3) begin
							fields.src_reg = op[6:3];
							if (op[7]) begin
								fields.mnemonic = tid_pkg::MN_BLX_R;
							end else begin
								fields.mnemonic      = tid_pkg::MN_BX;
								fields.falls_through = 1'b0;
							end
						end else if (op[9:8] == 2'd2 && imm8 == tid_pkg::NOP_LOW_BYTE) begin
							fields.mnemonic = tid_pkg::MN_NOP;
						end else begin
							fields.mnemonic = tid_pkg::MN_ADD_HI + {5'd0, op[9:8]};
							fields.dest_reg = {op[7], r0};
							fields.src_reg  = op[6:3];
						end
					end
					[3'd2:3'd3]: begin
						fields.mnemonic  = tid_pkg::MN_LDR_PC;
						fields.dest_reg  = {1'b0, r8};
						fields.src_reg   = tid_pkg::REG_PC;
						fields.immediate = {14'd0, imm8, 2'b00};
						req.data_en      = 1'b1;
					end
					default: begin
						fields.dest_reg   = {1'b0, r0};
						fields.src_reg    = {1'b0, r3};
						fields.offset_reg = r6;
						fields.mnemonic   = (op[9] ? tid_pkg::MN_LDST_HS_BASE
						                          : tid_pkg::MN_LDST_REG_BASE)
						                    + {5'd0, op[11:10]};
					end
				endcase
			end
			3'd3: begin
				fields.mnemonic  = tid_pkg::MN_LDST_I5_BASE + {5'd0, op[12:11]};
				fields.dest_reg  = {1'b0, r0};
				fields.src_reg   = {1'b0, r3};
				// words scale by 4, bytes by 1
				fields.immediate = op[12] ? {19'd0, imm5} : {17'd0, imm5, 2'b00};
			end
			3'd4: begin
				if (op[12]) begin
					fields.mnemonic  = op[11] ? tid_pkg::MN_LDR_SP : tid_pkg::MN_STR_SP;
					fields.dest_reg  = {1'b0, r8};
					fields.src_reg   = tid_pkg::REG_SP;
					fields.immediate = {14'd0, imm8, 2'b00};
				end else begin
					fields.mnemonic  = op[11] ? tid_pkg::MN_LDRH_I : tid_pkg::MN_STRH_I;
					fields.dest_reg  = {1'b0, r0};
					fields.src_reg   = {1'b0, r3};
					fields.immediate = {18'd0, imm5, 1'b0};
				end
			end
			3'd5: begin
				if (!op[12]) begin
					fields.mnemonic  = op[11] ? tid_pkg::MN_ADD_SPR : tid_pkg::MN_ADD_PC;
					fields.dest_reg  = {1'b0, r8};
					fields.src_reg   = op[11] ? tid_pkg::REG_SP : tid_pkg::REG_PC;
					fields.immediate = {14'd0, imm8, 2'b00};
				end else if (op[11:8] == 4'd0) begin
					fields.mnemonic  = tid_pkg::MN_ADD_SP_I;
					fields.dest_reg  = tid_pkg::REG_SP;
					fields.immediate = op[7] ? (24'd0 - {15'd0, sp_mag}) : {15'd0, sp_mag};
				end else if (op[10:9] == 2'd2) begin
					fields.reg_list = op[8:0];
					if (op[11]) begin
						fields.mnemonic      = tid_pkg::MN_POP;
						fields.falls_through = ~op[8];
					end else begin
						fields.mnemonic = tid_pkg::MN_PUSH;
					end
				end else if (r8 == 3'd6) begin
					fields.mnemonic  = tid_pkg::MN_BKPT;
					fields.immediate = {16'd0, imm8};
				end else begin
					fields.mnemonic  = tid_pkg::MN_UNDEF;
					fields.immediate = {8'd0, op};
				end
			end
			3'd6: begin
				if (op[12]) begin
					if (op[11:8] < tid_pkg::COND_UNDEF) begin
						fields.mnemonic  = tid_pkg::MN_BCOND;
						fields.condition = op[11:8];
						req.code_en      = 1'b1;
						req.soff         = {{3{imm8[7]}}, imm8};
					end else if (op[11:8] == tid_pkg::COND_UNDEF) begin
						fields.mnemonic  = tid_pkg::MN_UNDEF;
						fields.immediate = {8'd0, op};
					end else begin
						fields.mnemonic  = tid_pkg::MN_SWI;
						fields.immediate = {16'd0, imm8};
					end
				end else begin
					fields.mnemonic = op[11] ? tid_pkg::MN_LDMIA : tid_pkg::MN_STMIA;
					fields.dest_reg = {1'b0, r8};
					fields.reg_list = {1'b0, imm8};
				end
			end
			default: begin
				unique case (op[12:11])
					2'd0: begin
						fields.mnemonic      = tid_pkg::MN_B;
						fields.falls_through = 1'b0;
						req.code_en          = 1'b1;
						req.soff             = op[10:0];
					end
					2'd1: begin
						fields.mnemonic  = tid_pkg::MN_BLX_H;
						fields.immediate = {13'd0, op[10:0]};
					end
					2'd2: begin
						fields.mnemonic  = tid_pkg::MN_BL_P1;
						fields.immediate = {1'b0, op[10:0], 12'd0};
					end
					default: begin
						fields.mnemonic  = tid_pkg::MN_BL_H;
						fields.immediate = {13'd0, op[10:0]};
					end
				endcase
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/tid_target.sv
`timescale 1ns / 1ps
`default_nettype none

module tid_target (
	input  wire tid_pkg::out_word_t fields,
	input  wire tid_pkg::tgt_req_t  req,
	input  wire logic [31:0]        instr_address,
	input  wire logic [31:0]        rom_base,
	output tid_pkg::out_word_t      result
);

	logic [31:0] br_dist;
	logic [31:0] code_tgt;
	logic [31:0] pc_word;
	logic [31:0] data_tgt;

	// Branch distance 4 + 2*offset, then target address
	assign br_dist  = tid_pkg::PC_AHEAD + {{20{req.soff[10]}}, req.soff, 1'b0};
	assign code_tgt = instr_address + br_dist;

	// Literal address, word aligned PC plus scaled offset, ROM base bits cleared
	assign pc_word  = (instr_address + tid_pkg::PC_AHEAD) & tid_pkg::LIT_ALIGN_MASK;
	assign data_tgt = ({22'd0, req.imm8, 2'b00} + pc_word) & ~rom_base;

	always_comb begin
		result = fields;
		if (req.code_en) begin
			result.immediate         = br_dist[23:0];
			result.code_target_valid = 1'b1;
			result.code_target       = code_tgt;
		end
		if (req.data_en) begin
			result.data_target_valid = 1'b1;
			result.data_target       = data_tgt;
		end
	end

endmodule

`default_nettype wire
